/* rtl/rhc_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by rhc_front, rhc_cell and the top level.
package rhc_pkg;

	localparam int unsigned CHAN_W = 8;   // one color channel
	localparam int unsigned SAT_W = 16;   // saturation field and its quotient
	localparam int unsigned HUE_W = 16;   // hue field
	localparam int unsigned DIV_W = 11;   // 6*delta, at most 1530
	localparam int unsigned NUM_W = 13;   // signed hue numerator before wrap

	// hue sector offsets and the full turn, in units of delta
	localparam int unsigned SEC_G = 2;
	localparam int unsigned SEC_B = 4;
	localparam int unsigned SEC_TURN = 6;

	typedef struct packed {
		logic              valid;
		logic              grey;
		logic [CHAN_W-1:0] brightness;
	} rhc_ctl_t;

endpackage

/* rtl/rhc_front.sv */
// Front stage: max/min, sector numerator with wrap, and the seed values
// for both division chains. Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output rhc_ctl_t          ctl_s1,
	output logic [DIV_W-1:0]  hue_rem_s1,
	output logic [DIV_W-1:0]  hue_div_s1,
	output logic [CHAN_W-1:0] sat_rem_s1,
	output logic [CHAN_W-1:0] sat_div_s1,
	output logic [SAT_W-1:0]  sat_low_s1
);

	logic [CHAN_W-1:0] hi;
	logic [CHAN_W-1:0] lo;
	logic [CHAN_W-1:0] delta;
	logic [NUM_W-1:0]  d_ext;
	logic [NUM_W-1:0]  n_raw;
	logic [NUM_W-1:0]  n_wrap;
	logic [DIV_W-1:0]  d6;

	always_comb begin
		hi = (red > green) ? red : green;
		hi = (hi > blue) ? hi : blue;
		lo = (red < green) ? red : green;
		lo = (lo < blue) ? lo : blue;
		delta = hi - lo;
		d_ext = NUM_W'(delta);
		d6 = DIV_W'(d_ext * NUM_W'(SEC_TURN));
		// red wins ties, then green; two's complement at NUM_W bits
		if (red == hi) begin
			n_raw = NUM_W'(green) - NUM_W'(blue);
		end else if (green == hi) begin
			n_raw = d_ext * NUM_W'(SEC_G) + NUM_W'(blue) - NUM_W'(red);
		end else begin
			n_raw = d_ext * NUM_W'(SEC_B) + NUM_W'(red) - NUM_W'(green);
		end
		n_wrap = n_raw[NUM_W-1] ? (n_raw + NUM_W'(d6)) : n_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.grey <= (delta == '0);
			ctl_s1.brightness <= hi;
		end
	end

	// delta*65535 = (delta-1)*2^16 + (2^16-delta): seed remainder and low bits
	always_ff @(posedge clk) begin
		if (en) begin
			hue_rem_s1 <= n_wrap[DIV_W-1:0];
			hue_div_s1 <= d6;
			sat_rem_s1 <= delta - CHAN_W'(1);
			sat_div_s1 <= hi;
			sat_low_s1 <= SAT_W'(0) - SAT_W'(delta);
		end
	end

endmodule

/* rtl/rhc_cell.sv */
// One divider cell: hue and saturation restoring steps, each passed through
// when disabled, then the stage register. Depends on rhc_pkg.
module rhc_cell import rhc_pkg::*; #(
	parameter int unsigned QH_W = 16,
	parameter bit          HUE_ON = 1'b1,
	parameter bit          SAT_ON = 1'b1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rhc_ctl_t          ctl_i,
	input  logic [DIV_W-1:0]  hue_rem_i,
	input  logic [DIV_W-1:0]  hue_div_i,
	input  logic [QH_W-1:0]   hue_quo_i,
	input  logic [CHAN_W-1:0] sat_rem_i,
	input  logic [CHAN_W-1:0] sat_div_i,
	input  logic [SAT_W-1:0]  sat_low_i,
	input  logic [SAT_W-1:0]  sat_quo_i,
	output rhc_ctl_t          ctl_q,
	output logic [DIV_W-1:0]  hue_rem_q,
	output logic [DIV_W-1:0]  hue_div_q,
	output logic [QH_W-1:0]   hue_quo_q,
	output logic [CHAN_W-1:0] sat_rem_q,
	output logic [CHAN_W-1:0] sat_div_q,
	output logic [SAT_W-1:0]  sat_low_q,
	output logic [SAT_W-1:0]  sat_quo_q
);

	logic [DIV_W:0]    h_two;
	logic              h_bit;
	logic [DIV_W-1:0]  h_rem;
	logic [QH_W-1:0]   h_quo;
	logic [CHAN_W:0]   s_two;
	logic              s_bit;
	logic [CHAN_W-1:0] s_rem;
	logic [SAT_W-1:0]  s_low;
	logic [SAT_W-1:0]  s_quo;

	always_comb begin
		h_two = {hue_rem_i, 1'b0};
		h_bit = (h_two >= {1'b0, hue_div_i});
		if (HUE_ON) begin
			h_rem = h_bit ? DIV_W'(h_two - {1'b0, hue_div_i}) : h_two[DIV_W-1:0];
			h_quo = {hue_quo_i[QH_W-2:0], h_bit};
		end else begin
			h_rem = hue_rem_i;
			h_quo = hue_quo_i;
		end

		s_two = {sat_rem_i, sat_low_i[SAT_W-1]};
		s_bit = (s_two >= {1'b0, sat_div_i});
		if (SAT_ON) begin
			s_rem = s_bit ? CHAN_W'(s_two - {1'b0, sat_div_i}) : s_two[CHAN_W-1:0];
			s_low = {sat_low_i[SAT_W-2:0], 1'b0};
			s_quo = {sat_quo_i[SAT_W-2:0], s_bit};
		end else begin
			s_rem = sat_rem_i;
			s_low = sat_low_i;
			s_quo = sat_quo_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_rem_q <= h_rem;
			hue_div_q <= hue_div_i;
			hue_quo_q <= h_quo;
			sat_rem_q <= s_rem;
			sat_div_q <= sat_div_i;
			sat_low_q <= s_low;
			sat_quo_q <= s_quo;
		end
	end

`ifndef SYNTH
	// partial remainders stay below their divisors for colored pixels
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.valid && !ctl_q.grey |-> hue_rem_q < hue_div_q)
		else $error("hue remainder not below divisor");
	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.valid && !ctl_q.grey |-> sat_rem_q < sat_div_q)
		else $error("saturation remainder not below divisor");
`endif

endmodule

/* rtl/rgb_to_hsv_converter_unit.sv */
// RGB to HSV converter, top level: front stage plus a chain of divider cells.
// The chain holds one cell per quotient bit of the longer division.
// Throughput: one pixel per cycle; the chain advances whenever the output
// register is empty or being taken. Reset clears only the valid, grey and brightness fields.
// Depends on rhc_pkg, rhc_front, rhc_cell.
module rgb_to_hsv_converter_unit import rhc_pkg::*; #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [HUE_W-1:0]  hue,
	output logic [SAT_W-1:0]  saturation,
	output logic [CHAN_W-1:0] brightness
);

	localparam int unsigned STEPS = (FRACTION_BITS > SAT_W) ? FRACTION_BITS : SAT_W;

	logic                     en;
	rhc_ctl_t                 ctl      [0:STEPS];
	logic [DIV_W-1:0]         hue_rem  [0:STEPS];
	logic [DIV_W-1:0]         hue_div  [0:STEPS];
	logic [FRACTION_BITS-1:0] hue_quo  [0:STEPS];
	logic [CHAN_W-1:0]        sat_rem  [0:STEPS];
	logic [CHAN_W-1:0]        sat_div  [0:STEPS];
	logic [SAT_W-1:0]         sat_low  [0:STEPS];
	logic [SAT_W-1:0]         sat_quo  [0:STEPS];
	logic [HUE_W-1:0]         hue_clip;

	assign en = !ctl[STEPS].valid || out_ready;
	assign in_ready = en;

	rhc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.ctl_s1     (ctl[0]),
		.hue_rem_s1 (hue_rem[0]),
		.hue_div_s1 (hue_div[0]),
		.sat_rem_s1 (sat_rem[0]),
		.sat_div_s1 (sat_div[0]),
		.sat_low_s1 (sat_low[0])
	);

	assign hue_quo[0] = '0;
	assign sat_quo[0] = '0;

	// the shorter division idles in the leading cells so both end together
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		rhc_cell #(
			.QH_W   (FRACTION_BITS),
			.HUE_ON (i >= STEPS - FRACTION_BITS),
			.SAT_ON (i >= STEPS - SAT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.ctl_i     (ctl[i]),
			.hue_rem_i (hue_rem[i]),
			.hue_div_i (hue_div[i]),
			.hue_quo_i (hue_quo[i]),
			.sat_rem_i (sat_rem[i]),
			.sat_div_i (sat_div[i]),
			.sat_low_i (sat_low[i]),
			.sat_quo_i (sat_quo[i]),
			.ctl_q     (ctl[i+1]),
			.hue_rem_q (hue_rem[i+1]),
			.hue_div_q (hue_div[i+1]),
			.hue_quo_q (hue_quo[i+1]),
			.sat_rem_q (sat_rem[i+1]),
			.sat_div_q (sat_div[i+1]),
			.sat_low_q (sat_low[i+1]),
			.sat_quo_q (sat_quo[i+1])
		);
	end

	if (FRACTION_BITS > HUE_W) begin : g_hue_sat
		assign hue_clip = (|hue_quo[STEPS][FRACTION_BITS-1:HUE_W]) ? '1 :
			hue_quo[STEPS][HUE_W-1:0];
	end else begin : g_hue_ext
		assign hue_clip = HUE_W'(hue_quo[STEPS]);
	end

	assign out_valid = ctl[STEPS].valid;
	assign brightness = ctl[STEPS].brightness;
	assign hue = ctl[STEPS].grey ? '0 : hue_clip;
	assign saturation = ctl[STEPS].grey ? '0 : sat_quo[STEPS];

`ifndef SYNTH
	// any colored pixel has saturation of at least 65535/255
	a_sat_zero_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == '0 |-> hue == '0)
		else $error("hue nonzero on grey pixel");
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero hue or saturation");
	a_sat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ctl[STEPS].grey |-> saturation != '0)
		else $error("colored pixel with zero saturation");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready ##1
			(out_valid && $stable({hue, saturation, brightness})))
		else $error("chain advanced while output stalled");
`endif

endmodule
